FILE: src/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the channel hit merger
// Word formats, table sizing, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int CHAN_W   = 12;
    localparam int ENERGY_W = 32;
    localparam int TIME_W   = 32;

    localparam logic OP_HIT = 1'b0;
    localparam logic OP_EOE = 1'b1;

    typedef struct packed {
        logic                op;
        logic [CHAN_W-1:0]   channel;
        logic [ENERGY_W-1:0] energy;
        logic [TIME_W-1:0]   hit_time;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [ENERGY_W-1:0] energy_sum;
        logic [TIME_W-1:0]   first_time;
        logic                overflow;
        logic                last;
    } t_out_word;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [ENERGY_W-1:0] energy;
        logic [TIME_W-1:0]   etime;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } t_state;

endpackage

FILE: src/channel_hit_merger.sv
// ----------------------------------------------------------------------------
// channel_hit_merger: per-channel hit merging within one event
// Linear search over a table with one read and one write port, merge or append, and ordered
// emission of all entries at end of event.
// ----------------------------------------------------------------------------
// Hit word: busy while the table is scanned and, on a match, while the entry is updated;
// a new channel is appended if the table has room. One entry is scanned a cycle.
// End-of-event word: each entry emitted is read, then loaded into the output
// register, the load waiting while the output is stalled; an empty event only clears the overflow flag.
// Input is taken only in the idle state; the output register drains independently.
// Reset (synchronous, active low) empties the table and clears the overflow flag.
// ----------------------------------------------------------------------------
module channel_hit_merger (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  chm_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output chm_pkg::t_out_word o_out_word
);
    import chm_pkg::*;

    t_state    r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic      r_overflow, n_overflow;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic      r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0] r_match_idx, n_match_idx;
    t_in_word  r_hit;
    logic      r_out_vld, n_out_vld;
    t_out_word r_out, n_out;

    t_entry    r_mem [MAX_ENTRIES];
    t_entry    r_rd_data;
    logic      rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic      wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry    wr_data;

    logic      in_acc;
    logic      out_free;
    logic      issue;
    logic      match;
    logic      nomatch_done;
    logic      emit_last;
    logic [ENERGY_W:0] sum_ext;
    logic [ENERGY_W-1:0] sat_sum;
    logic [TIME_W-1:0]   min_time;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
    assign out_free    = !r_out_vld || !i_out_stall;

    assign issue        = (r_scan < r_count);
    assign match        = r_chk_vld && (r_rd_data.channel == r_hit.channel);
    assign nomatch_done = !issue && !r_chk_vld;
    assign emit_last    = (r_scan == (r_count - CNT_W'(1)));

    assign sum_ext  = {1'b0, r_rd_data.energy} + {1'b0, r_hit.energy};
    assign sat_sum  = sum_ext[ENERGY_W] ? {ENERGY_W{1'b1}} : sum_ext[ENERGY_W-1:0];
    assign min_time = (r_rd_data.etime > r_hit.hit_time) ? r_hit.hit_time
                                                         : r_rd_data.etime;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_word.op == OP_EOE) ? ST_EMIT_RD : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (match) begin
                    n_state = ST_UPDATE;
                end else if (nomatch_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_UPDATE: n_state = ST_IDLE;
            ST_EMIT_RD: begin
                n_state = (r_count == '0) ? ST_IDLE : ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                if (out_free) begin
                    n_state = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb begin
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_scan      = r_scan;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_match_idx = r_match_idx;
        n_out       = r_out;
        n_out_vld   = r_out_vld && i_out_stall;
        rd_en       = 1'b0;
        rd_addr     = r_scan[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_match_idx;
        wr_data     = '{channel: r_hit.channel, energy: r_hit.energy,
                        etime: r_hit.hit_time};
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_scan = '0;
                end
            end
            ST_SEARCH: begin
                // stop reading once matched so the read data holds
                rd_en     = issue && !match;
                n_chk_vld = rd_en;
                if (rd_en) begin
                    n_chk_idx = r_scan[IDX_W-1:0];
                    n_scan    = r_scan + CNT_W'(1);
                end
                if (match) begin
                    n_match_idx = r_chk_idx;
                end else if (nomatch_done) begin
                    if (r_count < CNT_W'(MAX_ENTRIES)) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[IDX_W-1:0];
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                end
            end
            ST_UPDATE: begin
                wr_en   = 1'b1;
                wr_addr = r_match_idx;
                wr_data = '{channel: r_rd_data.channel, energy: sat_sum,
                            etime: min_time};
            end
            ST_EMIT_RD: begin
                if (r_count == '0) begin
                    n_overflow = 1'b0;
                end else begin
                    rd_en = 1'b1;
                end
            end
            ST_EMIT_LOAD: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = '{out_channel: r_rd_data.channel,
                                  energy_sum:  r_rd_data.energy,
                                  first_time:  r_rd_data.etime,
                                  overflow:    r_overflow,
                                  last:        emit_last};
                    if (emit_last) begin
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_scan     = '0;
                    end else begin
                        n_scan = r_scan + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_scan     <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_chk_vld  <= n_chk_vld;
            r_out_vld  <= n_out_vld;
            r_scan     <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx   <= n_chk_idx;
        r_match_idx <= n_match_idx;
        r_out       <= n_out;
        if (in_acc) begin
            r_hit <= i_in_word;
        end
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

FILE: src/chm_checker.sv
// ----------------------------------------------------------------------------
// chm_checker: port-level checks for the channel hit merger
// Watches the handshakes and the emission sequence at the top-level ports.
// ----------------------------------------------------------------------------
module chm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input chm_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input chm_pkg::t_out_word o_out_word
);
    import chm_pkg::*;

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    // drop the output after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // every accepted input word leaves the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted back to back");

    // while a non-final entry waits, the event is still being emitted
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last) |-> o_in_stall)
        else $error("input open before last entry emitted");

    // an accepted hit word, whose opcode is sampled only on accept, starts a search
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_word.op == OP_HIT)) |=> o_in_stall)
        else $error("hit word did not start a search");

endmodule

bind channel_hit_merger chm_checker u_chm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

FILE: dv/channel_hit_merger_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_hit_merger_test: self-checking bench for the channel hit merger
// Sends hit and end-of-event words with random idling on both channels, keeps
// its own merge table to predict every emitted entry, and checks each output
// word in order against the prediction.
// ----------------------------------------------------------------------------
module channel_hit_merger_test;
    import chm_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 160;
    localparam int REPORT_MAX    = 10;

    typedef enum int {EV_MERGE, EV_SPREAD, EV_EMPTY} t_event_shape;

    class merge_scoreboard;
        logic [CHAN_W-1:0]   chan_tab   [MAX_ENTRIES];
        logic [ENERGY_W-1:0] energy_tab [MAX_ENTRIES];
        logic [TIME_W-1:0]   time_tab   [MAX_ENTRIES];
        int                  fill;
        bit                  dropped;
        t_out_word           pending [$];
        int mismatches, words_checked, events_emitted, overflow_events;
        int sat_sums, merges;

        function new();
            fill            = 0;
            dropped         = 1'b0;
            mismatches      = 0;
            words_checked   = 0;
            events_emitted  = 0;
            overflow_events = 0;
            sat_sums        = 0;
            merges          = 0;
        endfunction

        function void note_input(t_in_word w);
            int                match_idx;
            logic [ENERGY_W:0] sum;
            t_out_word         r;
            if (w.op == OP_HIT) begin
                match_idx = -1;
                for (int k = 0; k < fill; k++) begin
                    if (match_idx < 0 && chan_tab[k] == w.channel)
                        match_idx = k;
                end
                if (match_idx >= 0) begin
                    sum = {1'b0, energy_tab[match_idx]} + {1'b0, w.energy};
                    // clamp at all ones on carry out
                    if (sum[ENERGY_W]) begin
                        energy_tab[match_idx] = '1;
                        sat_sums++;
                    end else begin
                        energy_tab[match_idx] = sum[ENERGY_W-1:0];
                    end
                    if (w.hit_time < time_tab[match_idx])
                        time_tab[match_idx] = w.hit_time;
                    merges++;
                end else if (fill < MAX_ENTRIES) begin
                    chan_tab[fill]   = w.channel;
                    energy_tab[fill] = w.energy;
                    time_tab[fill]   = w.hit_time;
                    fill++;
                end else begin
                    dropped = 1'b1;
                end
            end else begin
                for (int k = 0; k < fill; k++) begin
                    r.out_channel = chan_tab[k];
                    r.energy_sum  = energy_tab[k];
                    r.first_time  = time_tab[k];
                    r.overflow    = dropped;
                    r.last        = (k == fill - 1);
                    pending.push_back(r);
                end
                if (fill > 0) begin
                    events_emitted++;
                    if (dropped)
                        overflow_events++;
                end
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_output(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected word: ch=%h energy=%h time=%h ovf=%b last=%b",
                             $time, got.out_channel, got.energy_sum, got.first_time,
                             got.overflow, got.last);
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (got.out_channel !== want.out_channel || got.energy_sum !== want.energy_sum ||
                got.first_time !== want.first_time || got.overflow !== want.overflow ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] mismatch: expected ch=%h energy=%h time=%h ovf=%b last=%b",
                             $time, want.out_channel, want.energy_sum, want.first_time,
                             want.overflow, want.last);
                    $display("            actual   ch=%h energy=%h time=%h ovf=%b last=%b",
                             got.out_channel, got.energy_sum, got.first_time,
                             got.overflow, got.last);
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int send_gap    = 0;
    int recv_gap    = 0;
    bit hold_req    = 1'b0;
    int items_sent  = 0;
    int idle_cycles = 0;

    merge_scoreboard sb = new();

    channel_hit_merger dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side pacing; a requested hold keeps the stall up for a long stretch.
    initial begin : rx_pacing
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_gap);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in_word);
                idle_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_output(o_out_word);
                idle_cycles = 0;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake, %0d words outstanding",
                         idle_cycles, sb.pending.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_in_word hit_word(logic [CHAN_W-1:0] ch, logic [ENERGY_W-1:0] en,
                                          logic [TIME_W-1:0] t);
        t_in_word w;
        w.op       = OP_HIT;
        w.channel  = ch;
        w.energy   = en;
        w.hit_time = t;
        return w;
    endfunction

    function automatic logic [ENERGY_W-1:0] rand_energy();
        case ($urandom_range(3))
            0:       return $urandom_range(1000);
            1:       return 32'hFFFF_FFFF - $urandom_range(3);
            2:       return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Times near a per-event base so that equal and earlier times show up often.
    function automatic logic [TIME_W-1:0] rand_time(logic [TIME_W-1:0] base_t);
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return base_t + $urandom_range(3);
            default: return base_t - $urandom_range(1000);
        endcase
    endfunction

    // Called and returns at a falling edge; valid stays up between back-to-back words.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_gap) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // End of event with random content in the unused fields.
    task automatic send_eoe();
        t_in_word w;
        w.op       = OP_EOE;
        w.channel  = CHAN_W'($urandom);
        w.energy   = $urandom;
        w.hit_time = $urandom;
        send_word(w);
    endtask

    task automatic random_event();
        int                roll;
        int                pool;
        int                n_hits;
        t_event_shape      shape;
        logic [CHAN_W-1:0] base_ch;
        logic [CHAN_W-1:0] ch;
        logic [TIME_W-1:0] base_t;
        roll    = $urandom_range(99);
        shape   = (roll < 60) ? EV_MERGE : ((roll < 92) ? EV_SPREAD : EV_EMPTY);
        base_ch = CHAN_W'($urandom);
        base_t  = $urandom;
        pool    = $urandom_range(1, 6);
        n_hits  = (shape == EV_EMPTY) ? 0 : $urandom_range(1, 12);
        for (int k = 0; k < n_hits; k++) begin
            if (shape == EV_MERGE)
                ch = base_ch + CHAN_W'($urandom_range(pool - 1));
            else
                ch = CHAN_W'($urandom);
            send_word(hit_word(ch, rand_energy(), rand_time(base_t)));
        end
        send_eoe();
    endtask

    // Fill the table with distinct channels; with spill, then mix dropped new
    // channels with merges into the full table.
    task automatic fill_event(input bit spill);
        logic [CHAN_W-1:0] base_ch;
        logic [TIME_W-1:0] base_t;
        base_ch = CHAN_W'($urandom);
        base_t  = $urandom;
        for (int k = 0; k < MAX_ENTRIES; k++)
            send_word(hit_word(base_ch + CHAN_W'(k), rand_energy(), rand_time(base_t)));
        if (spill) begin
            for (int k = 0; k < 6; k++) begin
                if (k % 2)
                    send_word(hit_word(base_ch + CHAN_W'($urandom_range(MAX_ENTRIES - 1)),
                                       rand_energy(), rand_time(base_t)));
                else
                    send_word(hit_word(base_ch + CHAN_W'(MAX_ENTRIES + k),
                                       rand_energy(), rand_time(base_t)));
            end
        end
        send_eoe();
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
            random_event();
    endtask

    // Hold the input side until every predicted word has been drained.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        t_in_word w;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_gap = 35;
        recv_gap = 86;

        // empty event, unused fields all ones
        w    = '1;
        w.op = OP_EOE;
        send_word(w);
        send_word(hit_word(12'h000, 32'h0000_0000, 32'hFFFF_FFFF));
        send_word(hit_word(12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000));
        // reach max exactly, then saturate; equal times keep the stored one
        send_word(hit_word(12'h000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(hit_word(12'h000, 32'h0000_0001, 32'hFFFF_FFFF));
        send_word(hit_word(12'hFFF, 32'h0000_0005, 32'h0000_0000));
        send_word(hit_word(12'h555, 32'h5555_5555, 32'hAAAA_AAAA));
        send_word(hit_word(12'hAAA, 32'hAAAA_AAAA, 32'h5555_5555));
        // earlier time replaces, later time is ignored
        send_word(hit_word(12'h555, 32'h0000_0000, 32'h1234_5678));
        send_word(hit_word(12'hAAA, 32'h0000_0001, 32'h5555_5556));
        w         = '0;
        w.op      = OP_EOE;
        w.channel = 12'hAAA;
        send_word(w);
        // single entry event carries last on its only word
        send_word(hit_word(12'h123, 32'h0000_0007, 32'h0000_0009));
        send_eoe();
        w    = '0;
        w.op = OP_EOE;
        send_word(w);

        fill_event(1'b1);
        run_random(170);
        wait_drained();

        send_gap = 86;
        recv_gap = 35;
        fill_event(1'b0);
        run_random(325);
        wait_drained();

        send_gap = 0;
        recv_gap = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        // keep offering words while the output is held off
        repeat (4) random_event();
        fill_event(1'b1);
        run_random(480);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d input words; %0d non-empty events emitted %0d checked words.",
                 items_sent, sb.events_emitted, sb.words_checked);
        $display("Table overflow in %0d events, %0d merges, %0d saturated sums, %0d mismatches.",
                 sb.overflow_events, sb.merges, sb.sat_sums, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
